FILE: src/multichannel_pwm_generator_top_macros.svh
// Assertion helpers for the PWM bank sequencer RTL.
// Each macro expects clk and rst to be visible in the using module.
`ifndef MULTICHANNEL_PWM_GENERATOR_TOP_MACROS_SVH
`define MULTICHANNEL_PWM_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define MPWM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MPWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/mpwm_pkg.sv
// ----------------------------------------------------------------------------
// mpwm_pkg
// Shared types and constants of the multichannel PWM bank.
// ----------------------------------------------------------------------------
package mpwm_pkg;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_ALLOC = 3'd1;
  localparam logic [2:0] OP_FREE  = 3'd2;
  localparam logic [2:0] OP_START = 3'd3;
  localparam logic [2:0] OP_STOP  = 3'd4;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_FREE     = 3'd1;
  localparam logic [2:0] ST_BAD_CHANNEL = 3'd2;
  localparam logic [2:0] ST_BAD_FREQ    = 3'd3;
  localparam logic [2:0] ST_BAD_DUTY    = 3'd4;
  localparam logic [2:0] ST_NOT_ALLOC   = 3'd5;

  // Highest usable frequency is below this many hertz per millisecond of tick.
  localparam logic [8:0] FMAX_PER_MS  = 9'd500;
  localparam logic [6:0] DUTY_FULL    = 7'd100;
  localparam logic [3:0] PHASE_SCALE  = 4'd10;
  localparam logic [3:0] DIV_STEPS    = 4'd10;

  localparam logic [7:0] TIMEBASE_RESET = 8'd1;
  localparam logic       REG_TIMEBASE   = 1'b0;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  channel;
    logic [16:0] frequency_hz;
    logic [6:0]  duty_percent;
    logic        pin_level;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] granted_channel;
    logic [7:0] levels;
    logic [7:0] toggled;
  } out_word_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_MUL    = 6'b000100,
    S_DIV    = 6'b001000,
    S_SCAN   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic mul;
    logic div;
    logic scan;
    logic deliver;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic start_go;
    logic div_last;
    logic scan_last;
  } sts_t;

endpackage

FILE: src/mpwm_ctrl.sv
// ----------------------------------------------------------------------------
// mpwm_ctrl
// Sequencer: steps one word through decode, multiply/divide or scan as needed, delivery.
// ----------------------------------------------------------------------------
`include "multichannel_pwm_generator_top_macros.svh"

module mpwm_ctrl import mpwm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_ready,
  output logic result_valid,
  input  logic result_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   out_free;

  assign out_free   = !result_valid || result_ready;
  assign item_ready = (state == S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.load    = item_valid && item_ready;
    cmd.decode  = (state == S_DECODE);
    cmd.mul     = (state == S_MUL);
    cmd.div     = (state == S_DIV);
    cmd.scan    = (state == S_SCAN);
    cmd.deliver = (state == S_DONE) && out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (item_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (sts.is_tick) state_next = S_SCAN;
        else if (sts.start_go) state_next = S_MUL;
        else state_next = S_DONE;
      end
      S_MUL:    state_next = S_DIV;
      S_DIV:    if (sts.div_last) state_next = S_DONE;
      S_SCAN:   if (sts.scan_last) state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.deliver) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

  `MPWM_ASSERT_NEXT(a_accept_decodes, cmd.load, state == S_DECODE, "accepted word not decoded")
  `MPWM_ASSERT_NOW(a_deliver_free, cmd.deliver, out_free, "delivery over a waiting result")
  `MPWM_ASSERT_NEXT(a_decode_once, state == S_DECODE, state != S_DECODE, "decode held")
  `MPWM_ASSERT_NEXT(a_deliver_valid, cmd.deliver, result_valid, "delivered result not shown")

endmodule

FILE: src/mpwm_datapath.sv
// ----------------------------------------------------------------------------
// mpwm_datapath
// Channel state, phase-length divider, tick scanner and result register.
// ----------------------------------------------------------------------------
module mpwm_datapath import mpwm_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  in_word_t   item_in,
  input  logic [7:0] timebase,
  output sts_t       sts,
  output out_word_t  result
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [5:0] CH_LIMIT = 6'(CHANNELS);
  localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);

  in_word_t item;
  logic [31:0] tick_count;
  logic [CHANNELS-1:0] allocated, running, level;
  logic [31:0] last_toggle [CHANNELS];
  logic [9:0]  high_ticks  [CHANNELS];
  logic [9:0]  low_ticks   [CHANNELS];

  logic [2:0] res_status, res_granted, status_d;
  logic [7:0] res_toggled;

  logic          ch_ok, freq_ok, duty_ok, free_found;
  logic [CW-1:0] ch_idx, free_idx, scan_idx;
  logic [16:0]   fmax;

  // divider
  logic [24:0] divisor, rem_h, rem_l;
  logic [9:0]  num_h, num_l, q_h, q_l, q_h_next, q_l_next;
  logic [25:0] sh_h, sh_l, sub_h, sub_l;
  logic        ge_h, ge_l;
  logic [3:0]  div_cnt;

  // scanner
  logic        fire;
  logic [31:0] elapsed;
  logic [9:0]  limit;

  logic [CHANNELS+7:0] level_ext;

  assign ch_ok   = {3'b000, item.channel} < CH_LIMIT;
  assign ch_idx  = CW'(item.channel);
  assign fmax    = 17'(FMAX_PER_MS) * 17'(timebase);
  assign freq_ok = (item.frequency_hz != 17'd0) && (item.frequency_hz < fmax);
  assign duty_ok = item.duty_percent <= DUTY_FULL;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (!allocated[i]) begin
        free_found = 1'b1;
        free_idx   = CW'(i);
      end
    end
  end

  always_comb begin
    case (item.opcode)
      OP_ALLOC: status_d = free_found ? ST_OK : ST_NO_FREE;
      OP_FREE:  status_d = ch_ok ? ST_OK : ST_BAD_CHANNEL;
      OP_START: begin
        if (!ch_ok) status_d = ST_BAD_CHANNEL;
        else if (!freq_ok) status_d = ST_BAD_FREQ;
        else if (!duty_ok) status_d = ST_BAD_DUTY;
        else if (!allocated[ch_idx]) status_d = ST_NOT_ALLOC;
        else status_d = ST_OK;
      end
      OP_STOP: begin
        if (!ch_ok) status_d = ST_BAD_CHANNEL;
        else if (!allocated[ch_idx]) status_d = ST_NOT_ALLOC;
        else status_d = ST_OK;
      end
      default:  status_d = ST_OK;
    endcase
  end

  assign sts.is_tick   = (item.opcode == OP_TICK);
  assign sts.start_go  = (item.opcode == OP_START) && (status_d == ST_OK);
  assign sts.div_last  = (div_cnt == DIV_STEPS - 4'd1);
  assign sts.scan_last = (scan_idx == LAST_CH);

  // one restoring step per cycle on both phase quotients
  assign sh_h  = {rem_h, num_h[9]};
  assign sh_l  = {rem_l, num_l[9]};
  assign ge_h  = sh_h >= {1'b0, divisor};
  assign ge_l  = sh_l >= {1'b0, divisor};
  assign sub_h = ge_h ? sh_h - {1'b0, divisor} : sh_h;
  assign sub_l = ge_l ? sh_l - {1'b0, divisor} : sh_l;
  assign q_h_next = {q_h[8:0], ge_h};
  assign q_l_next = {q_l[8:0], ge_l};

  assign elapsed = tick_count - last_toggle[scan_idx];
  assign limit   = level[scan_idx] ? high_ticks[scan_idx] : low_ticks[scan_idx];
  assign fire    = allocated[scan_idx] && running[scan_idx] && (elapsed > {22'd0, limit});

  assign level_ext = {8'd0, level};

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) item <= item_in;
    if (cmd.decode) begin
      res_status  <= status_d;
      res_granted <= (item.opcode == OP_ALLOC && free_found) ? 3'(free_idx) : 3'd0;
      res_toggled <= 8'd0;
      scan_idx    <= '0;
    end
    if (cmd.mul) begin
      divisor <= 25'(item.frequency_hz) * 25'(timebase);
      num_h   <= 10'(PHASE_SCALE) * 10'(item.duty_percent);
      num_l   <= 10'(PHASE_SCALE) * 10'(DUTY_FULL - item.duty_percent);
      rem_h   <= '0;
      rem_l   <= '0;
      q_h     <= '0;
      q_l     <= '0;
      div_cnt <= '0;
    end
    if (cmd.div) begin
      rem_h   <= sub_h[24:0];
      rem_l   <= sub_l[24:0];
      num_h   <= {num_h[8:0], 1'b0};
      num_l   <= {num_l[8:0], 1'b0};
      q_h     <= q_h_next;
      q_l     <= q_l_next;
      div_cnt <= div_cnt + 4'd1;
      if (sts.div_last) begin
        high_ticks[ch_idx]  <= q_h_next;
        low_ticks[ch_idx]   <= q_l_next;
        last_toggle[ch_idx] <= tick_count;
      end
    end
    if (cmd.scan) begin
      scan_idx <= scan_idx + 1'b1;
      if (fire) begin
        last_toggle[scan_idx] <= tick_count;
        if (int'(scan_idx) < 8) res_toggled[3'(scan_idx)] <= 1'b1;
      end
    end
    if (cmd.deliver) begin
      result.status          <= res_status;
      result.granted_channel <= res_granted;
      result.levels          <= level_ext[7:0];
      result.toggled         <= res_toggled;
    end
  end

  // channel control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      allocated  <= '0;
      running    <= '0;
      level      <= '0;
    end else begin
      if (cmd.decode) begin
        case (item.opcode)
          OP_TICK:  tick_count <= tick_count + 32'd1;
          OP_ALLOC: if (free_found) allocated[free_idx] <= 1'b1;
          OP_FREE:  if (ch_ok) allocated[ch_idx] <= 1'b0;
          OP_STOP:  if (status_d == ST_OK) begin
            running[ch_idx] <= 1'b0;
            level[ch_idx]   <= item.pin_level;
          end
          default:  ;
        endcase
      end
      if (cmd.div && sts.div_last) begin
        running[ch_idx] <= 1'b1;
        level[ch_idx]   <= item.pin_level;
      end
      if (cmd.scan && fire) level[scan_idx] <= !level[scan_idx];
    end
  end

endmodule

FILE: src/multichannel_pwm_generator_top.sv
// Sequence: a tick word is decoded, then scanned one channel per cycle; a start
// is decoded, multiplied and run through the ten-step restoring divider; other
// words go from decode straight to the output register.
// Throughput: one word at a time; the next word is taken once the result is
// handed to the output register, which frees the core while it waits.
// Reset (rst, synchronous): all channels free, stopped and low, tick count 0.
// ----------------------------------------------------------------------------
// multichannel_pwm_generator_top
// Bank of tick-timed PWM channels with an APB-style timebase register.
// ----------------------------------------------------------------------------
module multichannel_pwm_generator_top import mpwm_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // command words
  input  logic        item_valid,
  output logic        item_ready,
  input  in_word_t    item,
  // result words
  output logic        result_valid,
  input  logic        result_ready,
  output out_word_t   result,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] timebase;
  cmd_t       cmd;
  sts_t       sts;

  // Register file: one word, timebase in milliseconds per tick. Write on the
  // access phase. Software must change it only while the bank is idle, unchecked.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIMEBASE) ? {24'd0, timebase} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timebase <= TIMEBASE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_TIMEBASE) begin
      timebase <= pwdata[7:0];
    end
  end

  // Sequencer: accept, decode, then multiply and divide (start) or scan (tick),
  // and hand the finished word to the output register.
  mpwm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Datapath: channel flags, phase tables, divider and scanner.
  mpwm_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .item_in  (item),
    .timebase (timebase),
    .sts      (sts),
    .result   (result)
  );

endmodule
